@@ design/jmhp_pkg.sv @@
// shared types and constants for the jpeg marker and header parser
`default_nettype none

package jmhp_pkg;

	// marker bytes
	localparam logic [7:0] MARKER_PREFIX = 8'hFF;
	localparam logic [7:0] MARKER_SOI    = 8'hD8;
	localparam logic [7:0] MARKER_EOI    = 8'hD9;
	localparam logic [7:0] MARKER_SOS    = 8'hDA;
	localparam logic [7:0] MARKER_SOF0   = 8'hC0;
	localparam logic [7:0] MARKER_SOF3   = 8'hC3;
	localparam logic [7:0] MARKER_APP0   = 8'hE0;
	localparam logic [7:0] MARKER_RST0   = 8'hD0;
	localparam logic [7:0] MARKER_RST7   = 8'hD7;
	localparam logic [7:0] MARKER_TEM    = 8'h01;

	// fixed field lengths and limits
	localparam logic [15:0] SOF_FIXED_LEN  = 16'd8;
	localparam logic [15:0] APP0_FIXED_LEN = 16'd14;
	localparam logic [15:0] MIN_SEG_LEN    = 16'd2;
	localparam logic [3:0]  JFIF_TAG_LEN   = 4'd5;
	localparam logic [7:0]  MAX_UNITS      = 8'd2;

	// field offsets inside fixed header parts
	localparam logic [3:0] SOF_OFF_PREC   = 4'd0;
	localparam logic [3:0] SOF_OFF_HGT_HI = 4'd1;
	localparam logic [3:0] SOF_OFF_HGT_LO = 4'd2;
	localparam logic [3:0] SOF_OFF_WID_HI = 4'd3;
	localparam logic [3:0] SOF_OFF_WID_LO = 4'd4;
	localparam logic [3:0] SOF_OFF_COUNT  = 4'd5;
	localparam logic [3:0] SOF_OFF_LAST   = 4'd7;
	localparam logic [3:0] APP_OFF_UNITS  = 4'd7;
	localparam logic [3:0] APP_OFF_X_HI   = 4'd8;
	localparam logic [3:0] APP_OFF_X_LO   = 4'd9;
	localparam logic [3:0] APP_OFF_LAST   = 4'd13;

	// result status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NOT_JPEG    = 3'd1;
	localparam logic [2:0] ST_TRUNC_SOF   = 3'd2;
	localparam logic [2:0] ST_MISSING_SOF = 3'd3;
	localparam logic [2:0] ST_MISSING_EOI = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  sample_precision;
		logic [15:0] image_height;
		logic [15:0] image_width;
		logic [7:0]  component_count;
		logic [1:0]  coding_kind;
		logic        density_valid;
		logic [1:0]  density_units;
		logic [15:0] x_density;
	} out_item_t;

	// "JFIF\0" identifier bytes
	function automatic logic [7:0] jfif_tag_byte(input logic [2:0] idx);
		logic [7:0] val;
		case (idx)
			3'd0: val = 8'h4A;
			3'd1: val = 8'h46;
			3'd2: val = 8'h49;
			3'd3: val = 8'h46;
			3'd4: val = 8'h00;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

@@ design/jmhp_in_if.sv @@
// request channel carrying file bytes into the parser
`default_nettype none

interface jmhp_in_if;
	logic               valid;
	logic               ready;
	jmhp_pkg::in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ design/jmhp_out_if.sv @@
// request channel carrying one parse result per file
`default_nettype none

interface jmhp_out_if;
	logic                valid;
	logic                ready;
	jmhp_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ design/jpeg_marker_header_parser.sv @@
// top level: byte-serial jpeg marker walker with frame and jfif density capture
//
// channel     dir  handshake     payload
// file_data   in   valid/ready   data_byte[7:0], end_of_file
// result      out  valid/ready   status, frame header fields, jfif density
//
// one byte per cycle sustained while no waiting result holds the walker; a byte waits in
// the input register and its result, if any, is written to the result register as it advances
// the byte walker is a single registered state update per byte, no iteration
// arst_n clears the parse state and both valid flags; payload regs are not reset
// a result request still waiting holds the walker only on a byte that gives the
// next result; the input register then fills and file_data.ready drops until
// the waiting result request is taken
`default_nettype none

module jpeg_marker_header_parser (
	input  wire logic   clk,
	input  wire logic   arst_n,
	jmhp_in_if.sink     file_data,
	jmhp_out_if.source  result
);

	typedef enum logic [3:0] {
		P_START1,
		P_START2,
		P_SEEK,
		P_MARKER,
		P_LEN_HI,
		P_LEN_LO,
		P_SOF,
		P_APP0,
		P_SKIP,
		P_SKIPSCAN,
		P_SCAN,
		P_SCAN_FF,
		P_DONE
	} phase_t;

	// input register
	logic               valid_s1;
	jmhp_pkg::in_item_t item_s1;

	// result register
	logic                out_valid_q;
	jmhp_pkg::out_item_t out_item_q;

	// parse state
	phase_t      phase_q;
	logic [15:0] remain_q;
	logic [7:0]  len_hi_q;
	logic [7:0]  marker_q;
	logic [3:0]  offset_q;
	logic        jfif_match_q;
	logic [7:0]  units_q;
	logic [15:0] pend_x_q;
	logic [7:0]  pend_prec_q;
	logic [15:0] pend_height_q;
	logic [15:0] pend_width_q;
	logic [7:0]  pend_count_q;
	logic [7:0]  cap_prec_q;
	logic [15:0] cap_height_q;
	logic [15:0] cap_width_q;
	logic [7:0]  cap_count_q;
	logic [1:0]  cap_kind_q;
	logic        cap_dens_valid_q;
	logic [1:0]  cap_units_q;
	logic [15:0] cap_x_q;
	logic        found_frame_q;
	logic        found_end_q;
	logic        given_q;

	// next values
	phase_t      phase_n;
	logic [15:0] remain_n;
	logic [7:0]  len_hi_n;
	logic [7:0]  marker_n;
	logic [3:0]  offset_n;
	logic        jfif_match_n;
	logic [7:0]  units_n;
	logic [15:0] pend_x_n;
	logic [7:0]  pend_prec_n;
	logic [15:0] pend_height_n;
	logic [15:0] pend_width_n;
	logic [7:0]  pend_count_n;
	logic [7:0]  cap_prec_n;
	logic [15:0] cap_height_n;
	logic [15:0] cap_width_n;
	logic [7:0]  cap_count_n;
	logic [1:0]  cap_kind_n;
	logic        cap_dens_valid_n;
	logic [1:0]  cap_units_n;
	logic [15:0] cap_x_n;
	logic        found_frame_n;
	logic        found_end_n;
	logic        given_n;

	logic                res_fire;
	logic [2:0]          res_status;
	jmhp_pkg::out_item_t res_item;

	logic        advance;
	logic [7:0]  b;
	logic [15:0] seg_len;
	logic [15:0] seg_data;
	logic [15:0] remain_dec;
	logic        tag_hit;

	// the walker advances when its byte is present and any result it gives has a free slot
	assign advance         = valid_s1 && (!res_fire || !out_valid_q || result.ready);
	assign file_data.ready = !valid_s1 || advance;
	assign result.valid    = out_valid_q;
	assign result.item     = out_item_q;

	assign b          = item_s1.data_byte;
	assign seg_len    = {len_hi_q, b};
	assign seg_data   = seg_len - jmhp_pkg::MIN_SEG_LEN;
	assign remain_dec = remain_q - 16'd1;
	assign tag_hit    = (b == jmhp_pkg::jfif_tag_byte(offset_q[2:0]));

	always_comb begin
		phase_n          = phase_q;
		remain_n         = remain_q;
		len_hi_n         = len_hi_q;
		marker_n         = marker_q;
		offset_n         = offset_q;
		jfif_match_n     = jfif_match_q;
		units_n          = units_q;
		pend_x_n         = pend_x_q;
		pend_prec_n      = pend_prec_q;
		pend_height_n    = pend_height_q;
		pend_width_n     = pend_width_q;
		pend_count_n     = pend_count_q;
		cap_prec_n       = cap_prec_q;
		cap_height_n     = cap_height_q;
		cap_width_n      = cap_width_q;
		cap_count_n      = cap_count_q;
		cap_kind_n       = cap_kind_q;
		cap_dens_valid_n = cap_dens_valid_q;
		cap_units_n      = cap_units_q;
		cap_x_n          = cap_x_q;
		found_frame_n    = found_frame_q;
		found_end_n      = found_end_q;
		given_n          = given_q;
		res_fire         = 1'b0;
		res_status       = jmhp_pkg::ST_OK;

		case (phase_q)
			P_START1: begin
				if (b == jmhp_pkg::MARKER_PREFIX) begin
					phase_n = P_START2;
				end else begin
					res_fire   = 1'b1;
					res_status = jmhp_pkg::ST_NOT_JPEG;
				end
			end
			P_START2: begin
				if (b == jmhp_pkg::MARKER_SOI) begin
					phase_n = P_SEEK;
				end else begin
					res_fire   = 1'b1;
					res_status = jmhp_pkg::ST_NOT_JPEG;
				end
			end
			P_SEEK: begin
				if (b == jmhp_pkg::MARKER_PREFIX) begin
					phase_n = P_MARKER;
				end
			end
			P_MARKER: begin
				// fill bytes keep us here
				if (b == jmhp_pkg::MARKER_PREFIX) begin
					phase_n = P_MARKER;
				end else if (b == jmhp_pkg::MARKER_EOI) begin
					found_end_n = 1'b1;
					res_fire    = 1'b1;
					res_status  = found_frame_q ? jmhp_pkg::ST_OK
						: jmhp_pkg::ST_MISSING_SOF;
				end else if (b == jmhp_pkg::MARKER_TEM ||
						(b >= jmhp_pkg::MARKER_RST0 && b <= jmhp_pkg::MARKER_RST7)) begin
					// standalone marker, no length follows
					phase_n = P_SEEK;
				end else begin
					marker_n = b;
					phase_n  = P_LEN_HI;
				end
			end
			P_LEN_HI: begin
				len_hi_n = b;
				phase_n  = P_LEN_LO;
			end
			P_LEN_LO: begin
				if (seg_len < jmhp_pkg::MIN_SEG_LEN) begin
					res_fire   = 1'b1;
					res_status = found_frame_q ? jmhp_pkg::ST_MISSING_EOI
						: jmhp_pkg::ST_MISSING_SOF;
				end else begin
					remain_n = seg_data;
					offset_n = 4'd0;
					if (marker_q >= jmhp_pkg::MARKER_SOF0 &&
							marker_q <= jmhp_pkg::MARKER_SOF3) begin
						if (seg_data < jmhp_pkg::SOF_FIXED_LEN) begin
							res_fire   = 1'b1;
							res_status = jmhp_pkg::ST_TRUNC_SOF;
						end else begin
							phase_n = P_SOF;
						end
					end else if (marker_q == jmhp_pkg::MARKER_APP0 &&
							seg_data >= jmhp_pkg::APP0_FIXED_LEN) begin
						jfif_match_n = 1'b0;
						phase_n      = P_APP0;
					end else if (marker_q == jmhp_pkg::MARKER_SOS) begin
						phase_n = (seg_data == 16'd0) ? P_SCAN : P_SKIPSCAN;
					end else begin
						phase_n = (seg_data == 16'd0) ? P_SEEK : P_SKIP;
					end
				end
			end
			P_SOF: begin
				case (offset_q)
					jmhp_pkg::SOF_OFF_PREC:   pend_prec_n = b;
					jmhp_pkg::SOF_OFF_HGT_HI: pend_height_n[15:8] = b;
					jmhp_pkg::SOF_OFF_HGT_LO: pend_height_n[7:0] = b;
					jmhp_pkg::SOF_OFF_WID_HI: pend_width_n[15:8] = b;
					jmhp_pkg::SOF_OFF_WID_LO: pend_width_n[7:0] = b;
					jmhp_pkg::SOF_OFF_COUNT:  pend_count_n = b;
					default: pend_count_n = pend_count_q;
				endcase
				remain_n = remain_dec;
				offset_n = offset_q + 4'd1;
				if (offset_q >= jmhp_pkg::SOF_OFF_LAST) begin
					// frame header complete, coding kind from the marker
					cap_prec_n    = pend_prec_q;
					cap_height_n  = pend_height_q;
					cap_width_n   = pend_width_q;
					cap_count_n   = pend_count_q;
					cap_kind_n    = marker_q[1:0];
					found_frame_n = 1'b1;
					phase_n       = (remain_dec == 16'd0) ? P_SEEK : P_SKIP;
				end
			end
			P_APP0: begin
				if (offset_q < jmhp_pkg::JFIF_TAG_LEN) begin
					jfif_match_n = (offset_q == 4'd0) ? tag_hit : (jfif_match_q && tag_hit);
				end else if (offset_q == jmhp_pkg::APP_OFF_UNITS) begin
					units_n = b;
				end else if (offset_q == jmhp_pkg::APP_OFF_X_HI) begin
					pend_x_n = {b, 8'h00};
				end else if (offset_q == jmhp_pkg::APP_OFF_X_LO) begin
					pend_x_n = {pend_x_q[15:8], b};
				end
				remain_n = remain_dec;
				offset_n = offset_q + 4'd1;
				if (offset_q >= jmhp_pkg::APP_OFF_LAST) begin
					if (jfif_match_q && pend_x_q != 16'd0 && units_q <= jmhp_pkg::MAX_UNITS) begin
						cap_dens_valid_n = 1'b1;
						cap_units_n      = units_q[1:0];
						cap_x_n          = pend_x_q;
					end
					phase_n = (remain_dec == 16'd0) ? P_SEEK : P_SKIP;
				end
			end
			P_SKIP: begin
				remain_n = remain_dec;
				if (remain_dec == 16'd0) begin
					phase_n = P_SEEK;
				end
			end
			P_SKIPSCAN: begin
				remain_n = remain_dec;
				if (remain_dec == 16'd0) begin
					phase_n = P_SCAN;
				end
			end
			P_SCAN: begin
				if (b == jmhp_pkg::MARKER_PREFIX) begin
					phase_n = P_SCAN_FF;
				end
			end
			P_SCAN_FF: begin
				// any byte but EOI or a fill FF, such as a stuffed zero or a restart marker, drops back into entropy data
				if (b == jmhp_pkg::MARKER_EOI) begin
					found_end_n = 1'b1;
					res_fire    = 1'b1;
					res_status  = found_frame_q ? jmhp_pkg::ST_OK
						: jmhp_pkg::ST_MISSING_SOF;
				end else if (b != jmhp_pkg::MARKER_PREFIX) begin
					phase_n = P_SCAN;
				end
			end
			P_DONE: begin
				phase_n = P_DONE;
			end
			default: begin
				phase_n = P_DONE;
			end
		endcase

		// an early result parks the walker until end of file
		if (res_fire) begin
			given_n = 1'b1;
			phase_n = P_DONE;
		end

		// end of file: give the closing status unless one went out already
		if (item_s1.end_of_file && !given_n) begin
			res_fire = 1'b1;
			if (phase_n == P_START1 || phase_n == P_START2) begin
				res_status = jmhp_pkg::ST_NOT_JPEG;
			end else if (phase_n == P_SOF) begin
				res_status = jmhp_pkg::ST_TRUNC_SOF;
			end else if (!found_frame_n) begin
				res_status = jmhp_pkg::ST_MISSING_SOF;
			end else begin
				res_status = found_end_n ? jmhp_pkg::ST_OK : jmhp_pkg::ST_MISSING_EOI;
			end
		end

		// not-jpeg results carry zeroed fields
		res_item.status = res_status;
		if (res_status == jmhp_pkg::ST_NOT_JPEG) begin
			res_item.sample_precision = 8'd0;
			res_item.image_height     = 16'd0;
			res_item.image_width      = 16'd0;
			res_item.component_count  = 8'd0;
			res_item.coding_kind      = 2'd0;
			res_item.density_valid    = 1'b0;
			res_item.density_units    = 2'd0;
			res_item.x_density        = 16'd0;
		end else begin
			res_item.sample_precision = cap_prec_n;
			res_item.image_height     = cap_height_n;
			res_item.image_width      = cap_width_n;
			res_item.component_count  = cap_count_n;
			res_item.coding_kind      = cap_kind_n;
			res_item.density_valid    = cap_dens_valid_n;
			res_item.density_units    = cap_units_n;
			res_item.x_density        = cap_x_n;
		end

		// next file starts from the reset state
		if (item_s1.end_of_file) begin
			phase_n          = P_START1;
			remain_n         = 16'd0;
			len_hi_n         = 8'd0;
			marker_n         = 8'd0;
			offset_n         = 4'd0;
			jfif_match_n     = 1'b0;
			units_n          = 8'd0;
			cap_prec_n       = 8'd0;
			cap_height_n     = 16'd0;
			cap_width_n      = 16'd0;
			cap_count_n      = 8'd0;
			cap_kind_n       = 2'd0;
			cap_dens_valid_n = 1'b0;
			cap_units_n      = 2'd0;
			cap_x_n          = 16'd0;
			found_frame_n    = 1'b0;
			found_end_n      = 1'b0;
			given_n          = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			out_valid_q      <= 1'b0;
			phase_q          <= P_START1;
			remain_q         <= 16'd0;
			len_hi_q         <= 8'd0;
			marker_q         <= 8'd0;
			offset_q         <= 4'd0;
			jfif_match_q     <= 1'b0;
			units_q          <= 8'd0;
			cap_prec_q       <= 8'd0;
			cap_height_q     <= 16'd0;
			cap_width_q      <= 16'd0;
			cap_count_q      <= 8'd0;
			cap_kind_q       <= 2'd0;
			cap_dens_valid_q <= 1'b0;
			cap_units_q      <= 2'd0;
			cap_x_q          <= 16'd0;
			found_frame_q    <= 1'b0;
			found_end_q      <= 1'b0;
			given_q          <= 1'b0;
		end else begin
			// input register
			if (file_data.ready) begin
				valid_s1 <= file_data.valid;
			end

			// result register
			if (advance && res_fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (advance) begin
				phase_q          <= phase_n;
				remain_q         <= remain_n;
				len_hi_q         <= len_hi_n;
				marker_q         <= marker_n;
				offset_q         <= offset_n;
				jfif_match_q     <= jfif_match_n;
				units_q          <= units_n;
				cap_prec_q       <= cap_prec_n;
				cap_height_q     <= cap_height_n;
				cap_width_q      <= cap_width_n;
				cap_count_q      <= cap_count_n;
				cap_kind_q       <= cap_kind_n;
				cap_dens_valid_q <= cap_dens_valid_n;
				cap_units_q      <= cap_units_n;
				cap_x_q          <= cap_x_n;
				found_frame_q    <= found_frame_n;
				found_end_q      <= found_end_n;
				given_q          <= given_n;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (file_data.ready && file_data.valid) begin
			item_s1 <= file_data.item;
		end
		if (advance && res_fire) begin
			out_item_q <= res_item;
		end
		if (advance) begin
			pend_x_q      <= pend_x_n;
			pend_prec_q   <= pend_prec_n;
			pend_height_q <= pend_height_n;
			pend_width_q  <= pend_width_n;
			pend_count_q  <= pend_count_n;
		end
	end

endmodule

`default_nettype wire
